### src/text_console_writer_defines.svh
// Assertion macros of the console writer checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Clocked assertion, ignored while reset is held
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs across reset
`define TCW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcw_pkg.sv
// Shared constants, types and helper functions of the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  // Port field widths
  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int DELTA_W   = 8;
  localparam int IDX_W     = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  localparam int MV_W = ((COL_W > DELTA_W) ? COL_W : DELTA_W) + 2;

  localparam int TAB_STEP = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_TAB,
    CLS_BACKSPACE,
    CLS_PRINT
  } chr_class_t;

  typedef struct packed {
    op_t                      op;
    chr_class_t               cls;
    logic [CHAR_W-1:0]        ch;
    logic signed [DELTA_W-1:0] delta;
    logic [IDX_W-1:0]         index;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOVE,
    ST_READ,
    ST_READ_WAIT,
    ST_HIDE,
    ST_UPDATE,
    ST_SCRCHK,
    ST_SCROLL,
    ST_CLEAR,
    ST_PUT,
    ST_SHOW_RD,
    ST_SHOW_WR,
    ST_DONE
  } back_state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  function automatic logic [CELL_W-1:0] swap_colours(logic [CELL_W-1:0] c);
    return {c[11:8], c[15:12], c[7:0]};
  endfunction

  function automatic logic [CELL_W-1:0] blank_cell(logic [ATTR_W-1:0] attr);
    return {attr, CH_SPACE};
  endfunction

endpackage

### src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data
module tcw_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### src/tcw_front.sv
// Input side: accept beats and classify them into queue commands
module tcw_front (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tcw_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic signed [tcw_pkg::DELTA_W-1:0] in_move_delta,
  input  logic [tcw_pkg::IDX_W-1:0]          in_cell_index,
  input  logic                               q_full,
  input  logic                               init_busy,
  output logic                               push,
  output tcw_pkg::cmd_t                      push_cmd
);
  import tcw_pkg::*;

  chr_class_t cls;

  always_comb begin
    case (in_char_code)
      CH_NEWLINE:   cls = CLS_NEWLINE;
      CH_RETURN:    cls = CLS_RETURN;
      CH_TAB:       cls = CLS_TAB;
      CH_BACKSPACE: cls = CLS_BACKSPACE;
      default:      cls = CLS_PRINT;
    endcase
  end

  // Hold off input until the screen clear after reset is done
  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.op    = op_t'(in_opcode);
    push_cmd.cls   = cls;
    push_cmd.ch    = in_char_code;
    push_cmd.delta = in_move_delta;
    push_cmd.index = in_cell_index;
  end

endmodule

### src/tcw_queue.sv
// Short command queue between the front and back sides
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tcw_pkg::cmd_t head_cmd
);
  import tcw_pkg::*;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/tcw_back.sv
// Back side: cursor state, screen memory sequencing and the result register
module tcw_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]         cfg_wr_data,
  input  logic                               head_valid,
  input  tcw_pkg::cmd_t                      head_cmd,
  output logic                               pop,
  output logic                               init_busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tcw_pkg::ROW_OUT_W-1:0]      out_cursor_row_out,
  output logic [tcw_pkg::COL_OUT_W-1:0]      out_cursor_col_out,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_data,
  output logic                               out_move_taken
);
  import tcw_pkg::*;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CELL_W-1:0] saved_r, saved_nxt;
  logic              drawn_r, drawn_nxt;
  logic [ADDR_W-1:0] cur_addr_r, cur_addr_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic [CNT_W-1:0]  scr_r, scr_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic              taken_r, taken_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [COL_OUT_W-1:0] out_col_r, out_col_nxt;
  logic [CELL_W-1:0]    out_data_r, out_data_nxt;
  logic                 out_taken_r, out_taken_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic signed [MV_W-1:0]   move_col;
  logic                     move_ok;
  logic [COL_W:0]           tab_sum;
  logic [COL_W:0]           tab_col;
  logic [CNT_W+IDX_W-1:0]   idx_ext;
  logic                     idx_ok;
  logic [CNT_W-1:0]         scr_src;
  logic [CNT_W-1:0]         scr_dst;
  logic                     is_print;
  logic                     on_screen;

  tcw_ram #(
    .W     (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign move_col = signed'(MV_W'(col_r)) + MV_W'(cmd_r.delta);
  assign move_ok  = !move_col[MV_W-1] && (move_col < signed'(MV_W'(COLUMNS)));

  // Next tab stop, clipped at the right edge
  assign tab_sum = {1'b0, col_r} + (COL_W+1)'(TAB_STEP);
  assign tab_col = tab_sum & ~(COL_W+1)'(TAB_STEP - 1);

  assign idx_ext = (CNT_W+IDX_W)'(cmd_r.index);
  assign idx_ok  = idx_ext < (CNT_W+IDX_W)'(CELL_COUNT);

  assign scr_src = scr_r + CNT_W'(COLUMNS);
  assign scr_dst = scr_r - 1'b1;

  assign is_print  = (cmd_r.op == OP_PUT) && (cmd_r.cls == CLS_PRINT);
  assign on_screen = (col_r < COL_W'(COLUMNS)) && (row_r < ROW_W'(ROWS));

  assign attr_nxt  = cfg_wr_en ? cfg_wr_data : attr_r;
  assign init_busy = (state_r == ST_INIT);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    saved_nxt     = saved_r;
    drawn_nxt     = drawn_r;
    cur_addr_nxt  = cur_addr_r;
    scr_nxt       = scr_r;
    data_nxt      = data_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_data_nxt  = out_data_r;
    out_taken_nxt = out_taken_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = scr_r[ADDR_W-1:0];
        ram_wdata = RESET_CELL;
        if (scr_r == CNT_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          scr_nxt = scr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          cmd_nxt   = head_cmd;
          data_nxt  = '0;
          taken_nxt = 1'b0;
          case (head_cmd.op)
            OP_PUT:   state_nxt = ST_HIDE;
            OP_MOVE:  state_nxt = ST_MOVE;
            OP_CLEAR: state_nxt = ST_HIDE;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end

      ST_MOVE: begin
        if (move_ok) begin
          taken_nxt = 1'b1;
          state_nxt = ST_HIDE;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_READ: begin
        if (idx_ok) begin
          ram_raddr = idx_ext[ADDR_W-1:0];
          state_nxt = ST_READ_WAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_READ_WAIT: begin
        data_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end

      // Restore the cell under the cursor
      ST_HIDE: begin
        if (drawn_r) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr_r;
          ram_wdata = saved_r;
          drawn_nxt = 1'b0;
        end
        if (cmd_r.op == OP_CLEAR) begin
          scr_nxt   = '0;
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        state_nxt = ST_SCRCHK;
        if (cmd_r.op == OP_MOVE) begin
          col_nxt = move_col[COL_W-1:0];
        end else begin
          case (cmd_r.cls)
            CLS_NEWLINE: begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end
            CLS_RETURN: begin
              col_nxt = '0;
            end
            CLS_TAB: begin
              col_nxt = (tab_col > (COL_W+1)'(COLUMNS)) ? COL_W'(COLUMNS) : tab_col[COL_W-1:0];
            end
            CLS_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = cell_addr(row_r, col_r - 1'b1);
                ram_wdata = blank_cell(attr_r);
              end
            end
            default: begin
              // Pending wrap: advance to the next row first
              if (col_r >= COL_W'(COLUMNS)) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end
            end
          endcase
        end
      end

      ST_SCRCHK: begin
        if (row_r >= ROW_W'(ROWS)) begin
          scr_nxt   = '0;
          state_nxt = ST_SCROLL;
        end else if (is_print) begin
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_SHOW_RD;
        end
      end

      // Copy each cell up one row, writing it in the cycle after its read; blank the last row
      ST_SCROLL: begin
        ram_raddr = scr_src[ADDR_W-1:0];
        if (scr_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = scr_dst[ADDR_W-1:0];
          ram_wdata = (scr_r <= CNT_W'(CELL_COUNT - COLUMNS)) ? ram_rdata : blank_cell(attr_r);
        end
        if (scr_r == CNT_W'(CELL_COUNT)) begin
          row_nxt   = ROW_W'(ROWS - 1);
          state_nxt = is_print ? ST_PUT : ST_SHOW_RD;
        end else begin
          scr_nxt = scr_r + 1'b1;
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scr_r[ADDR_W-1:0];
        ram_wdata = blank_cell(attr_r);
        if (scr_r == CNT_W'(CELL_COUNT - 1)) begin
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = ST_SHOW_RD;
        end else begin
          scr_nxt = scr_r + 1'b1;
        end
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(row_r, col_r);
        ram_wdata = {attr_r, cmd_r.ch};
        col_nxt   = col_r + 1'b1;
        state_nxt = ST_SHOW_RD;
      end

      ST_SHOW_RD: begin
        if (on_screen) begin
          ram_raddr    = cell_addr(row_r, col_r);
          cur_addr_nxt = cell_addr(row_r, col_r);
          state_nxt    = ST_SHOW_WR;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Save the cell and store it reversed
      ST_SHOW_WR: begin
        saved_nxt = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = cur_addr_r;
        ram_wdata = swap_colours(ram_rdata);
        drawn_nxt = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = ROW_OUT_W'(row_r);
          out_col_nxt   = COL_OUT_W'(col_r);
          out_data_nxt  = data_r;
          out_taken_nxt = taken_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      scr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      saved_r     <= '0;
      drawn_r     <= 1'b0;
      cur_addr_r  <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scr_r       <= scr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      saved_r     <= saved_nxt;
      drawn_r     <= drawn_nxt;
      cur_addr_r  <= cur_addr_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    data_r      <= data_nxt;
    taken_r     <= taken_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_data_r  <= out_data_nxt;
    out_taken_r <= out_taken_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;
  assign out_cell_data      = out_data_r;
  assign out_move_taken     = out_taken_r;

endmodule

### src/text_console_writer.sv
// Top level of the text console writer: front side, command queue and back side
// The console keeps an 80 x 25 screen of 16-bit cells (attribute above character)
// in a single-write, single-read memory, and every beat yields one result beat.
// After reset the block blanks the screen to 0x0720 with in_ready low; cfg
// writes are taken throughout. Beats enter a two-entry queue, so in_ready
// stays high while the back side works until two beats are waiting.
// At the back side a scroll copies one cell per cycle, then blanks the last
// row. When the cursor ends parked at the width it is not drawn. A held
// result beat does not block the queue.
module text_console_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tcw_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic signed [tcw_pkg::DELTA_W-1:0] in_move_delta,
  input  logic [tcw_pkg::IDX_W-1:0]          in_cell_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tcw_pkg::ROW_OUT_W-1:0]      out_cursor_row_out,
  output logic [tcw_pkg::COL_OUT_W-1:0]      out_cursor_col_out,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_data,
  output logic                               out_move_taken
);
  import tcw_pkg::*;

  logic init_busy;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  tcw_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_move_delta (in_move_delta),
    .in_cell_index (in_cell_index),
    .q_full        (q_full),
    .init_busy     (init_busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .head_valid         (head_valid),
    .head_cmd           (head_cmd),
    .pop                (pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cell_data      (out_cell_data),
    .out_move_taken     (out_move_taken)
  );

endmodule

### src/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level
`include "text_console_writer_defines.svh"

module tcw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::ROW_OUT_W-1:0] out_cursor_row_out,
  input logic [tcw_pkg::COL_OUT_W-1:0] out_cursor_col_out,
  input logic [tcw_pkg::CELL_W-1:0]    out_cell_data,
  input logic                          out_move_taken
);
  import tcw_pkg::*;

  `TCW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cell_data) && $stable(out_cursor_col_out) && $stable(out_cursor_row_out), "result beat changed while stalled")
  `TCW_ASSERT(a_row_range, out_valid |-> out_cursor_row_out < ROW_OUT_W'(ROWS), "cursor row past last row")
  `TCW_ASSERT(a_col_range, out_valid |-> out_cursor_col_out <= COL_OUT_W'(COLUMNS), "cursor column past width")
  `TCW_ASSERT(a_move_no_data, out_valid && out_move_taken |-> out_cell_data == '0, "move result carries cell data")
  `TCW_ASSERT_RST(a_init_blocks, !rst_n |=> !in_ready, "input taken during screen clear after reset")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

### test/text_console_writer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer: random console traffic against a screen predictor
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_LEN  = 100;
  localparam int PRINT_LIMIT  = 40;

  typedef enum {STEP_BEAT, STEP_ATTR} step_kind_e;
  typedef enum {MIX_PROSE, MIX_ANY, MIX_SCROLL, MIX_EDGE} traffic_mix_e;

  typedef struct {
    step_kind_e                kind;
    op_t                       op;
    logic [CHAR_W-1:0]         ch;
    logic signed [DELTA_W-1:0] delta;
    logic [IDX_W-1:0]          index;
    bit                        aim_cursor;
    logic [ATTR_W-1:0]         attr;
  } console_step_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [CELL_W-1:0]    data;
    logic                 taken;
  } cursor_report_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0]         cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       in_opcode = '0;
  logic [CHAR_W-1:0]         in_char_code = '0;
  logic signed [DELTA_W-1:0] in_move_delta = '0;
  logic [IDX_W-1:0]          in_cell_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ROW_OUT_W-1:0]      out_cursor_row_out;
  logic [COL_OUT_W-1:0]      out_cursor_col_out;
  logic [CELL_W-1:0]         out_cell_data;
  logic                      out_move_taken;

  text_console_writer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_move_delta      (in_move_delta),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cell_data      (out_cell_data),
    .out_move_taken     (out_move_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Screen predictor state
  logic [CELL_W-1:0] screen_copy [CELL_COUNT];
  int unsigned       row_now;
  int unsigned       col_now;
  int unsigned       cursor_cell;
  logic [CELL_W-1:0] cell_under_cursor;
  bit                cursor_shown;
  logic [ATTR_W-1:0] attr_now;

  console_step_t  queued_commands[$];
  cursor_report_t reports_due[$];
  int             mismatch_count = 0;

  function automatic logic [CELL_W-1:0] attr_blank();
    return {attr_now, CH_SPACE};
  endfunction

  function automatic void restore_cursor_cell();
    if (cursor_shown) begin
      if (cursor_cell < CELL_COUNT) screen_copy[cursor_cell] = cell_under_cursor;
      cursor_shown = 0;
    end
  endfunction

  function automatic void draw_cursor();
    logic [CELL_W-1:0] c;
    if (col_now >= COLUMNS || row_now >= ROWS) return;
    cursor_cell = row_now * COLUMNS + col_now;
    c = screen_copy[cursor_cell];
    cell_under_cursor = c;
    // reverse video: trade foreground and background nibbles
    screen_copy[cursor_cell] = {c[11:8], c[15:12], c[7:0]};
    cursor_shown = 1;
  endfunction

  function automatic void scroll_when_past_bottom();
    if (row_now >= ROWS) begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_copy[i] = attr_blank();
      row_now = ROWS - 1;
    end
  endfunction

  function automatic void put_character(logic [CHAR_W-1:0] ch);
    restore_cursor_cell();
    case (ch)
      CH_NEWLINE: begin
        col_now = 0;
        row_now++;
      end
      CH_RETURN: begin
        col_now = 0;
      end
      CH_TAB: begin
        col_now = (col_now + TAB_STEP) & ~(TAB_STEP - 1);
        if (col_now > COLUMNS) col_now = COLUMNS;
      end
      CH_BACKSPACE: begin
        if (col_now > 0) begin
          col_now--;
          screen_copy[row_now * COLUMNS + col_now] = attr_blank();
        end
      end
      default: begin
        // wrap first when parked past the last column
        if (col_now >= COLUMNS) begin
          col_now = 0;
          row_now++;
        end
        scroll_when_past_bottom();
        screen_copy[row_now * COLUMNS + col_now] = {attr_now, ch};
        col_now++;
      end
    endcase
    scroll_when_past_bottom();
    draw_cursor();
  endfunction

  function automatic cursor_report_t apply_console_op(console_step_t s);
    cursor_report_t r;
    int             target;
    r = '0;
    case (s.op)
      OP_PUT: begin
        put_character(s.ch);
      end
      OP_MOVE: begin
        target = int'(col_now) + int'($signed(s.delta));
        if (target >= 0 && target < COLUMNS) begin
          restore_cursor_cell();
          col_now = target;
          draw_cursor();
          r.taken = 1'b1;
        end
      end
      OP_CLEAR: begin
        restore_cursor_cell();
        foreach (screen_copy[i]) screen_copy[i] = attr_blank();
        row_now = 0;
        col_now = 0;
        draw_cursor();
      end
      default: begin
        if (s.index < CELL_COUNT) r.data = screen_copy[s.index];
      end
    endcase
    r.row = ROW_OUT_W'(row_now);
    r.col = COL_OUT_W'(col_now);
    return r;
  endfunction

  function automatic console_step_t beat(op_t op, int ch, int delta, int index);
    console_step_t s;
    s.kind       = STEP_BEAT;
    s.op         = op;
    s.ch         = CHAR_W'(ch);
    s.delta      = DELTA_W'(delta);
    s.index      = IDX_W'(index);
    s.aim_cursor = 0;
    s.attr       = '0;
    return s;
  endfunction

  function automatic console_step_t random_step(traffic_mix_e mix);
    int            roll;
    int            ch;
    int            delta;
    int            index;
    op_t           op;
    console_step_t s;
    roll  = $urandom_range(0, 99);
    ch    = $urandom_range(0, 255);
    delta = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                        : int'($urandom_range(0, 160)) - 80;
    index = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 2047))
                                        : int'($urandom_range(0, CELL_COUNT - 1));
    op = OP_READ;
    case (mix)
      MIX_PROSE: begin
        if (roll < 60) op = OP_PUT;
        else if (roll < 70) begin op = OP_PUT; ch = CH_NEWLINE; end
        else if (roll < 74) begin op = OP_PUT; ch = CH_RETURN; end
        else if (roll < 79) begin op = OP_PUT; ch = CH_TAB; end
        else if (roll < 85) begin op = OP_PUT; ch = CH_BACKSPACE; end
        else if (roll < 92) op = OP_MOVE;
      end
      MIX_ANY: begin
        if (roll < 45) op = OP_PUT;
        else if (roll < 60) op = OP_MOVE;
        else if (roll < 63) op = OP_CLEAR;
      end
      MIX_SCROLL: begin
        if (roll < 25) begin op = OP_PUT; ch = CH_NEWLINE; end
        else if (roll < 85) op = OP_PUT;
      end
      default: begin
        if (roll < 25) begin op = OP_PUT; ch = CH_TAB; end
        else if (roll < 40) begin op = OP_PUT; ch = CH_BACKSPACE; end
        else if (roll < 65) op = OP_MOVE;
        else if (roll < 80) op = OP_PUT;
      end
    endcase
    s = beat(op, ch, delta, index);
    // resolve the address at send time so that reads land on or beside the cursor
    if (op == OP_READ && $urandom_range(0, 2) == 0) s.aim_cursor = 1;
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Sender
  console_step_t in_flight;
  bit            beat_taken;
  bit            valid_next;
  bit            write_next;
  int            send_hold;
  bit            send_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_wr_en <= 1'b0;
      send_hold = 0;
      send_calm = 0;
    end else begin
      beat_taken = in_valid && in_ready;
      if (beat_taken) reports_due.push_back(apply_console_op(in_flight));
      valid_next = in_valid && !beat_taken;
      write_next = 1'b0;
      if (!valid_next && queued_commands.size() > 0) begin
        if (queued_commands[0].kind == STEP_ATTR) begin
          // hold the attribute change until every outstanding beat has come back
          if (reports_due.size() == 0) begin
            write_next = 1'b1;
            cfg_wr_data <= queued_commands[0].attr;
            attr_now = queued_commands[0].attr;
            void'(queued_commands.pop_front());
          end
        end else if (send_hold > 0) begin
          send_hold--;
        end else begin
          in_flight = queued_commands.pop_front();
          if (in_flight.aim_cursor) begin
            in_flight.index = IDX_W'(row_now * COLUMNS + col_now + $urandom_range(0, 2) - 1);
          end
          in_opcode     <= in_flight.op;
          in_char_code  <= in_flight.ch;
          in_move_delta <= in_flight.delta;
          in_cell_index <= in_flight.index;
          valid_next = 1'b1;
          if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
          send_hold = send_calm ? 0 : $urandom_range(0, 11);
        end
      end
      in_valid  <= valid_next;
      cfg_wr_en <= write_next;
    end
  end

  // Receiver
  cursor_report_t want;
  int             recv_hold;
  bit             recv_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
      recv_calm = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding",
                          {out_cursor_row_out, out_cursor_col_out, out_cell_data,
                           out_move_taken}, 0);
        end else begin
          want = reports_due.pop_front();
          if (out_cursor_row_out !== want.row) begin
            report_mismatch("cursor row", out_cursor_row_out, want.row);
          end
          if (out_cursor_col_out !== want.col) begin
            report_mismatch("cursor column", out_cursor_col_out, want.col);
          end
          if (out_cell_data !== want.data) begin
            report_mismatch("cell data", out_cell_data, want.data);
          end
          if (out_move_taken !== want.taken) begin
            report_mismatch("move taken", out_move_taken, want.taken);
          end
        end
        if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
        recv_hold = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: clear and scroll walk the whole screen, so allow well beyond one of those
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("text_console_writer_test: errors");
        $finish;
      end
    end
  end

  initial begin
    console_step_t s;
    traffic_mix_e  mix;
    foreach (screen_copy[i]) screen_copy[i] = RESET_CELL;
    row_now           = 0;
    col_now           = 0;
    cursor_cell       = 0;
    cell_under_cursor = '0;
    cursor_shown      = 0;
    attr_now          = RESET_ATTR;

    // Directed opening at the reset attribute
    queued_commands.push_back(beat(OP_PUT, 8'h41, 0, 0));
    queued_commands.push_back(beat(OP_PUT, 8'h00, 0, 0));
    queued_commands.push_back(beat(OP_PUT, 8'hFF, 0, 0));
    queued_commands.push_back(beat(OP_READ, 0, 0, 0));
    queued_commands.push_back(beat(OP_READ, 0, 0, 3));
    queued_commands.push_back(beat(OP_PUT, CH_BACKSPACE, 0, 0));
    queued_commands.push_back(beat(OP_PUT, CH_RETURN, 0, 0));
    queued_commands.push_back(beat(OP_PUT, CH_BACKSPACE, 0, 0));
    queued_commands.push_back(beat(OP_PUT, CH_TAB, 0, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, 80, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, -128, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, 73, 0));
    // tab from column 77 saturates at the width, then again while parked there
    queued_commands.push_back(beat(OP_PUT, CH_TAB, 0, 0));
    queued_commands.push_back(beat(OP_PUT, CH_TAB, 0, 0));
    queued_commands.push_back(beat(OP_READ, 0, 0, 79));
    queued_commands.push_back(beat(OP_PUT, 8'h7E, 0, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, -1, 0));
    queued_commands.push_back(beat(OP_PUT, CH_NEWLINE, 0, 0));
    queued_commands.push_back(beat(OP_READ, 0, 0, CELL_COUNT - 1));
    queued_commands.push_back(beat(OP_READ, 0, 0, CELL_COUNT));
    queued_commands.push_back(beat(OP_READ, 0, 0, 2047));
    queued_commands.push_back(beat(OP_CLEAR, 0, 0, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, 127, 0));
    queued_commands.push_back(beat(OP_MOVE, 0, 79, 0));
    queued_commands.push_back(beat(OP_PUT, CH_BACKSPACE, 0, 0));

    // Random segments, each under its own attribute and traffic mix
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      s = beat(OP_READ, 0, 0, 0);
      s.kind = STEP_ATTR;
      s.attr = (seg == 0) ? 8'hFF : (seg == 1) ? 8'h00 : ATTR_W'($urandom_range(0, 255));
      queued_commands.push_back(s);
      mix = (seg == 0) ? MIX_PROSE : (seg == 1) ? MIX_SCROLL
                                                : traffic_mix_e'($urandom_range(0, 3));
      repeat (SEGMENT_LEN) queued_commands.push_back(random_step(mix));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the sender's updates have settled
    while (queued_commands.size() > 0 || in_valid || reports_due.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_writer_test: clean");
    end else begin
      $display("text_console_writer_test: errors");
    end
    $finish;
  end

endmodule
